// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/ncsl_pkg.sv =====
package ncsl_pkg;

    // field widths
    localparam int CODE_W      = 5;
    localparam int NIB_W       = 4;
    localparam int MODE_W      = 4;
    localparam int ADDR_W      = 10;
    localparam int DATA_W      = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    // command codes
    localparam logic [CODE_W-1:0] CMD_POS_RESET    = 5'd16;
    localparam logic [CODE_W-1:0] CMD_START_TX     = 5'd26;
    localparam logic [CODE_W-1:0] CMD_REPEAT_ON    = 5'd27;
    localparam logic [CODE_W-1:0] CMD_REPEAT_OFF   = 5'd28;
    localparam logic [CODE_W-1:0] CMD_SWAP         = 5'd29;
    localparam logic [CODE_W-1:0] CMD_EOP_SWAP_OFF = 5'd30;
    localparam logic [CODE_W-1:0] CMD_EOP_SWAP_ON  = 5'd31;

    // data modes
    localparam logic [MODE_W-1:0] MODE_INDEX = 4'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO  = 4'd3;

    // result item, first field in the highest bits
    typedef struct packed {
        logic              busy_level;
        logic              swap_on_eop;
        logic              swap_mode_write;
        logic              swap_now;
        logic              repeat_value;
        logic              repeat_write;
        logic              start_tx;
        logic [DATA_W-1:0] buf_data;
        logic [ADDR_W-1:0] buf_addr;
        logic              buf_bank;
        logic              buf_write;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

// ===== rtl/core/nibble_command_slot_loader.sv =====
// Nibble command slot loader: takes one 5-bit code per item on the slave
// stream (commands 16..31, data nibbles 0..15) and returns exactly one result
// item per code on the master stream, carrying the back-bank write (slot,
// byte, bank), the command pulses and the toggled busy level. It accepts one
// code every cycle while the output is not stalled; a code passes an input
// register and then a result register before its result is offered, and a
// stall on the master side holds the slave side after both registers fill.
// In auto-advance mode the slot wraps to 0 at SLOT_COUNT (2..513); a slot set
// at or above SLOT_COUNT by index nibbles is still written once before
// wrapping.
module nibble_command_slot_loader #(
    parameter int SLOT_COUNT = 513
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // code[4:0], zeros[7:5]
    input  logic [ncsl_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // buf_write[0], buf_bank[1], buf_addr[11:2], buf_data[19:12], start_tx[20],
    // repeat_write[21], repeat_value[22], swap_now[23], swap_mode_write[24],
    // swap_on_eop[25], busy_level[26], zeros[31:27]
    output logic [ncsl_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    logic                        w_in_valid;
    logic [ncsl_pkg::CODE_W-1:0] w_in_code;
    logic                        w_out_free;
    logic                        w_move;
    ncsl_pkg::t_result           w_res;
    ncsl_pkg::t_result           w_out_res;

    // an item moves into the result register when there is room
    assign w_move = w_in_valid && w_out_free;

    ncsl_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_code   (i_s_tdata[ncsl_pkg::CODE_W-1:0]),
        .i_take   (w_move),
        .o_valid  (w_in_valid),
        .o_code   (w_in_code)
    );

    ncsl_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_move),
        .i_code  (w_in_code),
        .o_res   (w_res)
    );

    ncsl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_move),
        .i_res    (w_res),
        .o_free   (w_out_free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_res    (w_out_res)
    );

    // pack the result, padded to whole bytes
    assign o_m_tdata = {{(ncsl_pkg::OUT_TDATA_W - ncsl_pkg::RES_W){1'b0}}, w_out_res};

endmodule

// ===== rtl/core/ncsl_in_stage.sv =====
module ncsl_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [ncsl_pkg::CODE_W-1:0]   i_code,
    input  logic                          i_take,
    output logic                          o_valid,
    output logic [ncsl_pkg::CODE_W-1:0]   o_code
);

    logic                        r_valid;
    logic                        n_valid;
    logic [ncsl_pkg::CODE_W-1:0] r_code;
    logic                        w_accept;

    // room when empty or when the held item moves on this cycle
    assign o_tready = !r_valid || i_take;
    assign w_accept = i_tvalid && o_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // code register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code <= i_code;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;

endmodule

// ===== rtl/core/ncsl_engine.sv =====
module ncsl_engine #(
    parameter int SLOT_COUNT = 513
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [ncsl_pkg::CODE_W-1:0]   i_code,
    output ncsl_pkg::t_result             o_res
);

    localparam int ADDR_W = ncsl_pkg::ADDR_W;
    localparam logic [ADDR_W:0] LP_COUNT = (ADDR_W + 1)'(SLOT_COUNT);

    // index nibble positions
    localparam logic [1:0] POS_LOW  = 2'd0;
    localparam logic [1:0] POS_MID  = 2'd1;
    localparam logic [1:0] POS_HIGH = 2'd2;

    logic [ncsl_pkg::MODE_W-1:0] r_mode,  n_mode;
    logic [ADDR_W-1:0]           r_slot,  n_slot;
    logic [1:0]                  r_pos,   n_pos;
    logic [ncsl_pkg::DATA_W-1:0] r_value, n_value;
    logic                        r_upper, n_upper;
    logic                        r_bank,  n_bank;
    logic                        r_busy,  n_busy;

    logic [ncsl_pkg::NIB_W-1:0]  w_nib;
    logic [ADDR_W-1:0]           w_slot_inc;

    assign w_nib      = i_code[ncsl_pkg::NIB_W-1:0];
    assign w_slot_inc = r_slot + ADDR_W'(1);

    // decode one code and work out the next state and the result
    always_comb begin
        n_mode  = r_mode;
        n_slot  = r_slot;
        n_pos   = r_pos;
        n_value = r_value;
        n_upper = r_upper;
        n_bank  = r_bank;
        n_busy  = ~r_busy;
        o_res   = '0;

        if (i_code[ncsl_pkg::CODE_W-1]) begin
            // command
            case (i_code)
                ncsl_pkg::CMD_START_TX: begin
                    o_res.start_tx = 1'b1;
                end
                ncsl_pkg::CMD_REPEAT_ON: begin
                    o_res.repeat_write = 1'b1;
                    o_res.repeat_value = 1'b1;
                end
                ncsl_pkg::CMD_REPEAT_OFF: begin
                    o_res.repeat_write = 1'b1;
                end
                ncsl_pkg::CMD_SWAP: begin
                    o_res.swap_now = 1'b1;
                    n_bank         = ~r_bank;
                end
                ncsl_pkg::CMD_EOP_SWAP_OFF: begin
                    o_res.swap_mode_write = 1'b1;
                end
                ncsl_pkg::CMD_EOP_SWAP_ON: begin
                    o_res.swap_mode_write = 1'b1;
                    o_res.swap_on_eop     = 1'b1;
                end
                ncsl_pkg::CMD_POS_RESET: begin
                end
                default: begin
                    // mode select commands
                    n_mode = w_nib;
                end
            endcase
            n_pos   = POS_LOW;
            n_upper = 1'b0;
        end else if (r_mode == ncsl_pkg::MODE_INDEX) begin
            // slot index nibbles, low first, bit 8 last
            case (r_pos)
                POS_LOW: begin
                    n_slot = {1'b0, r_slot[8:4], w_nib};
                    n_pos  = POS_MID;
                end
                POS_MID: begin
                    n_slot = {1'b0, r_slot[8], w_nib, r_slot[3:0]};
                    n_pos  = POS_HIGH;
                end
                POS_HIGH: begin
                    n_slot = {1'b0, w_nib[0], r_slot[7:0]};
                    n_pos  = POS_LOW;
                end
                default: begin
                end
            endcase
        end else if (r_mode > ncsl_pkg::MODE_INDEX) begin
            // value nibbles, low first; the high one completes the byte
            if (!r_upper) begin
                n_value = {r_value[7:4], w_nib};
                n_upper = 1'b1;
            end else begin
                n_value        = {w_nib, r_value[3:0]};
                n_upper        = 1'b0;
                o_res.buf_write = 1'b1;
                o_res.buf_addr  = r_slot;
                o_res.buf_data  = {w_nib, r_value[3:0]};
                if (r_mode == ncsl_pkg::MODE_AUTO) begin
                    if ({1'b0, w_slot_inc} >= LP_COUNT) begin
                        n_slot = '0;
                    end else begin
                        n_slot = w_slot_inc;
                    end
                end
            end
        end

        o_res.buf_bank   = n_bank;
        o_res.busy_level = n_busy;
    end

    // loader state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ncsl_pkg::MODE_INDEX;
            r_slot  <= '0;
            r_pos   <= POS_LOW;
            r_value <= '0;
            r_upper <= 1'b0;
            r_bank  <= 1'b1;
            r_busy  <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_slot  <= n_slot;
            r_pos   <= n_pos;
            r_value <= n_value;
            r_upper <= n_upper;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

endmodule

// ===== rtl/core/ncsl_out_stage.sv =====
module ncsl_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ncsl_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_tvalid,
    input  logic              i_tready,
    output ncsl_pkg::t_result o_res
);

    logic              r_valid;
    logic              n_valid;
    ncsl_pkg::t_result r_res;

    // free when empty or when the held result is taken this cycle
    assign o_free = !r_valid || i_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;

endmodule

// ===== rtl/core/ncsl_checker.sv =====
`include "assert_macros.svh"

module ncsl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [ncsl_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [ncsl_pkg::OUT_TDATA_W-1:0]  i_m_tdata
);

    ncsl_pkg::t_result w_res;
    logic              w_out_take;
    logic              w_in_take;
    logic              w_idle_ok;
    logic              w_one_action;
    logic              r_last_busy;
    logic              r_seen_in;

    assign w_res      = i_m_tdata[ncsl_pkg::RES_W-1:0];
    assign w_out_take = i_m_tvalid && i_m_tready;
    assign w_in_take  = i_s_tvalid && i_s_tready;

    // zero slot and byte, and at most one action with its value bits
    assign w_idle_ok    = (w_res.buf_addr == '0) && (w_res.buf_data == '0);
    assign w_one_action = $onehot0({w_res.buf_write, w_res.start_tx, w_res.repeat_write,
                                    w_res.swap_now, w_res.swap_mode_write})
                          && (!w_res.repeat_value || w_res.repeat_write)
                          && (!w_res.swap_on_eop || w_res.swap_mode_write);

    // busy level of the last result taken, and whether any code went in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_busy <= 1'b0;
            r_seen_in   <= 1'b0;
        end else begin
            if (w_out_take) begin
                r_last_busy <= w_res.busy_level;
            end
            if (w_in_take) begin
                r_seen_in <= 1'b1;
            end
        end
    end

    // a stalled result holds
    `AST_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))

    // busy level flips from one result to the next
    `AST_IMP(a_busy_toggle, i_clk, i_rst_n, w_out_take, w_res.busy_level != r_last_busy)

    // no write means zero slot and byte
    `AST_IMP(a_idle_write, i_clk, i_rst_n, i_m_tvalid && !w_res.buf_write, w_idle_ok)

    // at most one action per result, and value bits only with their strobes
    `AST_IMP(a_one_action, i_clk, i_rst_n, i_m_tvalid, w_one_action)

    // no result before any code was taken
    `AST_IMP(a_no_invent, i_clk, i_rst_n, i_m_tvalid, r_seen_in)

endmodule

bind nibble_command_slot_loader ncsl_checker u_ncsl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
